### design/pmlm_pkg.sv
// ----------------------------------------------------------------------------
// pmlm_pkg
// Shared types and constants of the peak and RMS level meter.
// ----------------------------------------------------------------------------
package pmlm_pkg;

  localparam int SUM_BITS  = 64;
  localparam int CNT_BITS  = 32;
  localparam int ROOT_BITS = 32;
  localparam int WIN_BITS  = 16;
  localparam int STEP_BITS = 6;

  localparam logic [WIN_BITS-1:0] RMS_WINDOW_RESET = 16'd13230;

  // configuration register indexes
  localparam logic REG_STEREO_MODE = 1'b0;
  localparam logic REG_RMS_WINDOW  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } pmlm_state_t;

endpackage

### design/peak_rms_level_meter.sv
// ----------------------------------------------------------------------------
// peak_rms_level_meter
// Per-buffer peak and windowed RMS meter for stereo frames, bit-serial
// squaring, restoring division and digit-by-digit square root.
// ----------------------------------------------------------------------------
//  channel | beat                                     | handshake
//  in_     | tdata {right, left}, tlast = buffer end  | in_tvalid / in_tready
//  out_    | tdata {rms_r, rms_l, peak_r, peak_l}     | out_tvalid / out_tready
//  cfg_    | cfg_index, cfg_data                      | cfg_valid / cfg_ready
//
// Each frame is taken in IDLE, squared in MUL by one shift-add step per
// multiplier bit for both channels in parallel, and summed in ACC. A buffer
// end goes on to EMIT to hand over the result; when the window is reached the
// 64-step divider and the 32-step root run first. One frame is in work at a time. The output
// register holds a result while the next frame is taken; a second result
// waits until it drains. Reset is synchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
module peak_rms_level_meter
  import pmlm_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // left_sample, right_sample (lowest bit first), zero padded
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // peak_left, peak_right, rms_left, rms_right (lowest bit first), zero padded
  output logic [((4*SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [WIN_BITS-1:0]       cfg_data
);

  localparam int N = SAMPLE_BITS;
  localparam int OUT_W = ((4*SAMPLE_BITS+7)/8)*8;
  localparam logic [N-1:0] SIGN_VAL = {1'b1, {(N-1){1'b0}}};

  pmlm_state_t state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;

  logic                stereo_r;
  logic [WIN_BITS-1:0] window_r;

  logic              last_r, last_nxt;
  logic [N-1:0]      mag_r   [2];
  logic [N-1:0]      mag_nxt [2];
  logic [2*N-1:0]    prod_r  [2];
  logic [2*N-1:0]    prod_nxt[2];
  logic [N-1:0]      peak_r  [2];
  logic [N-1:0]      peak_nxt[2];
  logic [SUM_BITS-1:0] sum_r  [2];
  logic [SUM_BITS-1:0] sum_nxt[2];
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0] drem_r  [2];
  logic [CNT_BITS-1:0] drem_nxt[2];
  logic [ROOT_BITS+2:0] srem_r  [2];
  logic [ROOT_BITS+2:0] srem_nxt[2];
  logic [ROOT_BITS-1:0] root_r  [2];
  logic [ROOT_BITS-1:0] root_nxt[2];
  logic [N-1:0]      rms_r   [2];
  logic [N-1:0]      rms_nxt [2];

  logic              out_valid_r, out_valid_nxt;
  logic [4*N-1:0]    out_data_r, out_data_nxt;

  // working values of the step logic
  logic [N-1:0]          raw_smp [2];
  logic [N:0]            mul_sum [2];
  logic [SUM_BITS:0]     acc_sum [2];
  logic [CNT_BITS:0]     div_sh  [2];
  logic [ROOT_BITS+2:0]  sq_sh   [2];
  logic [ROOT_BITS+2:0]  sq_try  [2];
  logic [CNT_BITS-1:0]   cnt_inc;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  assign raw_smp[0] = in_tdata[N-1:0];
  assign raw_smp[1] = stereo_r ? in_tdata[2*N-1:N] : in_tdata[N-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b1;
      window_r <= RMS_WINDOW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEREO_MODE: stereo_r <= cfg_data[0];
        REG_RMS_WINDOW:  window_r <= cfg_data;
        default:         stereo_r <= stereo_r;
      endcase
    end
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int c = 0; c < 2; c++) begin
        peak_r[c] <= '0;
        sum_r[c]  <= '0;
        rms_r[c]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      for (int c = 0; c < 2; c++) begin
        peak_r[c] <= peak_nxt[c];
        sum_r[c]  <= sum_nxt[c];
        rms_r[c]  <= rms_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    for (int c = 0; c < 2; c++) begin
      mag_r[c]  <= mag_nxt[c];
      prod_r[c] <= prod_nxt[c];
      drem_r[c] <= drem_nxt[c];
      srem_r[c] <= srem_nxt[c];
      root_r[c] <= root_nxt[c];
    end
  end

  // next state and datapath steps
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cnt_inc       = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    for (int c = 0; c < 2; c++) begin
      mag_nxt[c]  = mag_r[c];
      prod_nxt[c] = prod_r[c];
      peak_nxt[c] = peak_r[c];
      sum_nxt[c]  = sum_r[c];
      drem_nxt[c] = drem_r[c];
      srem_nxt[c] = srem_r[c];
      root_nxt[c] = root_r[c];
      rms_nxt[c]  = rms_r[c];
      mul_sum[c]  = {1'b0, prod_r[c][2*N-1:N]} + (prod_r[c][0] ? {1'b0, mag_r[c]} : '0);
      acc_sum[c]  = {1'b0, sum_r[c]} + (SUM_BITS+1)'(prod_r[c]);
      div_sh[c]   = {drem_r[c], sum_r[c][SUM_BITS-1]};
      sq_sh[c]    = {srem_r[c][ROOT_BITS:0], sum_r[c][SUM_BITS-1 -: 2]};
      sq_try[c]   = {1'b0, root_r[c], 2'b01};
    end

    // drain the output register
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          // take the frame and form magnitudes
          last_nxt = in_tlast;
          for (int c = 0; c < 2; c++) begin
            mag_nxt[c]  = raw_smp[c][N-1] ? (~raw_smp[c] + 1'b1) : raw_smp[c];
            prod_nxt[c] = {{N{1'b0}}, mag_nxt[c]};
          end
          step_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // one shift-add step per multiplier bit
        for (int c = 0; c < 2; c++) begin
          prod_nxt[c] = {mul_sum[c], prod_r[c][N-1:1]};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(N - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        // update peaks, saturating sums and frame count
        for (int c = 0; c < 2; c++) begin
          if (mag_r[c] > peak_r[c]) peak_nxt[c] = mag_r[c];
          sum_nxt[c] = acc_sum[c][SUM_BITS] ? '1 : acc_sum[c][SUM_BITS-1:0];
          drem_nxt[c] = '0;
          srem_nxt[c] = '0;
          root_nxt[c] = '0;
        end
        cnt_nxt  = cnt_inc;
        step_nxt = '0;
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (cnt_inc >= CNT_BITS'(window_r)) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        // restoring division; the sum register shifts into the quotient
        for (int c = 0; c < 2; c++) begin
          if (div_sh[c] >= {1'b0, cnt_r}) begin
            drem_nxt[c] = CNT_BITS'(div_sh[c] - {1'b0, cnt_r});
            sum_nxt[c]  = {sum_r[c][SUM_BITS-2:0], 1'b1};
          end else begin
            drem_nxt[c] = div_sh[c][CNT_BITS-1:0];
            sum_nxt[c]  = {sum_r[c][SUM_BITS-2:0], 1'b0};
          end
        end
        step_nxt = step_r + 1'b1;
        if (step_r == '1) begin
          step_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // two quotient bits per step into the root
        for (int c = 0; c < 2; c++) begin
          sum_nxt[c] = {sum_r[c][SUM_BITS-3:0], 2'b00};
          if (sq_sh[c] >= sq_try[c]) begin
            srem_nxt[c] = sq_sh[c] - sq_try[c];
            root_nxt[c] = {root_r[c][ROOT_BITS-2:0], 1'b1};
          end else begin
            srem_nxt[c] = sq_sh[c];
            root_nxt[c] = {root_r[c][ROOT_BITS-2:0], 1'b0};
          end
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(ROOT_BITS - 1)) begin
          // clamp, hold and clear the window
          for (int c = 0; c < 2; c++) begin
            sum_nxt[c] = '0;
            rms_nxt[c] = (root_nxt[c] > ROOT_BITS'(SIGN_VAL)) ? SIGN_VAL
                                                              : N'(root_nxt[c]);
          end
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {rms_r[1], rms_r[0], peak_r[1], peak_r[0]};
          peak_nxt[0]   = '0;
          peak_nxt[1]   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // a result appears only from the hand-over state
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside hand-over");

  // the divisor is never zero while dividing
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r != '0))
    else $error("division by zero count");

  // held RMS never passes full scale
  a_rms_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (rms_r[0] <= SIGN_VAL) && (rms_r[1] <= SIGN_VAL))
    else $error("RMS above full scale");

  // window cleared once a root completes
  a_win_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT && state_nxt == ST_EMIT) |=> (cnt_r == '0))
    else $error("window not cleared");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the peak and RMS level meter: a queue-fed driver,
// a monitor checking each result beat against a behavioural predictor,
// random stalls on both sides and several register settings.
// ----------------------------------------------------------------------------
module tb;
  import pmlm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = 24;
  localparam int IN_W = ((2*SB+7)/8)*8;
  localparam logic [63:0] SIGN = 64'd1 << (SB-1);
  localparam int LIMIT = 20000;

  typedef struct packed {
    logic [SB-1:0] left;
    logic [SB-1:0] right;
    logic          last;
  } frame_t;

  // lowest field last: peak_l sits in the lowest bits of the beat
  typedef struct packed {
    logic [SB-1:0] rms_r;
    logic [SB-1:0] rms_l;
    logic [SB-1:0] peak_r;
    logic [SB-1:0] peak_l;
  } level_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, in_tready, in_tlast = 0;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [4*SB-1:0] out_tdata;
  logic cfg_valid = 0, cfg_ready, cfg_index = REG_STEREO_MODE;
  logic [WIN_BITS-1:0] cfg_data = '0;

  peak_rms_level_meter #(.SAMPLE_BITS(SB)) uut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic          mdl_stereo;
  logic [15:0]   mdl_window;
  logic [63:0]   pk_l, pk_r, sq_l, sq_r, rh_l, rh_r;
  logic [31:0]   n_frames;

  frame_t frame_q[$];
  level_t level_q[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     hold_out = 0;
  bit     feeding = 1;

  function automatic logic [63:0] mag(logic [SB-1:0] s);
    if (s[SB-1]) return (64'd1 << SB) - {40'd0, s};
    return {40'd0, s};
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] root_of(logic [63:0] sum, logic [31:0] cnt);
    logic [63:0] x, r, b;
    x = sum / cnt;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return (r > SIGN) ? SIGN : r;
  endfunction

  // advance the level predictor by one frame
  task automatic predict_levels(frame_t f);
    logic [63:0] ml, mr;
    level_t lv;
    ml = mag(f.left);
    mr = mdl_stereo ? mag(f.right) : ml;
    if (ml > pk_l) pk_l = ml;
    if (mr > pk_r) pk_r = mr;
    sq_l = sat_sum(sq_l, ml * ml);
    sq_r = sat_sum(sq_r, mr * mr);
    if (n_frames != '1) n_frames++;
    if (f.last) begin
      if (n_frames >= {16'd0, mdl_window}) begin
        rh_l = root_of(sq_l, n_frames);
        rh_r = root_of(sq_r, n_frames);
        sq_l = 0; sq_r = 0; n_frames = 0;
      end
      lv.peak_l = pk_l[SB-1:0];
      lv.peak_r = pk_r[SB-1:0];
      lv.rms_l  = rh_l[SB-1:0];
      lv.rms_r  = rh_r[SB-1:0];
      level_q = {level_q, lv};
      pk_l = 0; pk_r = 0;
    end
  endtask

  task automatic report(string what, logic [SB-1:0] got, logic [SB-1:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: offer queued frames with random gaps
  int gap_in = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_levels(frame_q.pop_front());
        gap_in <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 18));
        in_tvalid <= 0;
      end else if (!in_tvalid && feeding && frame_q.size() > 0) begin
        if (gap_in > 0) gap_in <= gap_in - 1;
        else begin
          in_tvalid <= 1;
          in_tdata  <= {frame_q[0].right, frame_q[0].left};
          in_tlast  <= frame_q[0].last;
        end
      end
    end
  end

  // monitor: compare result beats, stall the receiver at random
  int gap_out = 0;
  always @(posedge clk) begin
    level_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (level_q.size() == 0) begin
          report("unexpected result", got.peak_l, '0);
        end else begin
          want = level_q.pop_front();
          if (got.peak_l !== want.peak_l) report("peak_left", got.peak_l, want.peak_l);
          if (got.peak_r !== want.peak_r) report("peak_right", got.peak_r, want.peak_r);
          if (got.rms_l !== want.rms_l) report("rms_left", got.rms_l, want.rms_l);
          if (got.rms_r !== want.rms_r) report("rms_right", got.rms_r, want.rms_r);
        end
        gap_out <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 18));
        out_tready <= 0;
      end else if (hold_out) begin
        out_tready <= 0;
      end else if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else if (frame_q.size() > 0 || level_q.size() > 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_STEREO_MODE) mdl_stereo = val[0];
    else mdl_window = val;
    cfg_valid <= 0;
  endtask

  // wait until every result is in, then let the block settle
  task automatic drain();
    while (frame_q.size() > 0 || level_q.size() > 0 || in_tvalid) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      default: return SB'($urandom());
    endcase
  endfunction

  task automatic queue_buffers(int frames, int max_len);
    frame_t f;
    int len;
    len = $urandom_range(1, max_len);
    for (int i = 0; i < frames; i++) begin
      f.left  = rand_sample();
      f.right = rand_sample();
      len--;
      f.last = (len == 0) || (i == frames - 1);
      if (len == 0) len = $urandom_range(1, max_len);
      frame_q = {frame_q, f};
    end
  endtask

  task automatic queue_frame(logic [SB-1:0] l, logic [SB-1:0] r, logic last);
    frame_t f;
    f.left = l; f.right = r; f.last = last;
    frame_q = {frame_q, f};
  endtask

  initial begin
    mdl_stereo = 1; mdl_window = RMS_WINDOW_RESET;
    pk_l = 0; pk_r = 0; sq_l = 0; sq_r = 0; rh_l = 0; rh_r = 0; n_frames = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: reset window holds RMS at zero, extremes of the samples
    queue_frame(24'h800000, 24'h7FFFFF, 1);
    queue_frame(24'h7FFFFF, 24'h800000, 0);
    queue_frame(24'h000000, 24'hFFFFFF, 1);
    drain();
    write_reg(REG_RMS_WINDOW, 16'd1);
    queue_frame(24'h800000, 24'h800000, 1);
    queue_frame(24'h000001, 24'h7FFFFF, 0);
    queue_frame(24'hFFFFFF, 24'h000000, 1);
    queue_frame(24'h123456, 24'hABCDEF, 1);
    drain();
    write_reg(REG_STEREO_MODE, 16'd0);
    queue_frame(24'h800000, 24'h000000, 1);
    queue_frame(24'h400000, 24'h7FFFFF, 0);
    queue_frame(24'hC00000, 24'h800000, 1);
    drain();
    write_reg(REG_RMS_WINDOW, 16'd0);
    queue_frame(24'h7FFFFF, 24'h000001, 1);
    queue_frame(24'h000000, 24'h800000, 1);
    drain();

    // random phases across settings
    write_reg(REG_STEREO_MODE, 16'd1);
    write_reg(REG_RMS_WINDOW, 16'd3);
    queue_buffers(120, 6);
    drain();

    // receiver holds off while frames keep coming
    hold_out = 1;
    queue_buffers(20, 2);
    repeat (1500) @(posedge clk);
    hold_out = 0;
    drain();

    write_reg(REG_STEREO_MODE, 16'd0);
    write_reg(REG_RMS_WINDOW, 16'd7);
    queue_buffers(100, 5);
    drain();

    write_reg(REG_STEREO_MODE, 16'd1);
    write_reg(REG_RMS_WINDOW, 16'd1);
    queue_buffers(100, 3);
    drain();

    // sender pauses with results outstanding
    queue_buffers(40, 4);
    while (frame_q.size() > 0) @(posedge clk);
    feeding = 0;
    while (level_q.size() > 0 || in_tvalid) @(posedge clk);
    feeding = 1;
    drain();

    write_reg(REG_RMS_WINDOW, 16'd65535);
    queue_buffers(60, 8);
    drain();
    write_reg(REG_RMS_WINDOW, 16'd40);
    queue_buffers(120, 10);
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### files.f
design/pmlm_pkg.sv
design/peak_rms_level_meter.sv
tb/tb.sv
